/* design/wall_clock_time_code_converter_macros.svh */
// Assertion helpers used by the asserting module.
`ifndef WALL_CLOCK_TIME_CODE_CONVERTER_MACROS_SVH
`define WALL_CLOCK_TIME_CODE_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcc assertion failed");

`endif

/* design/wcc_pkg.sv */
package wcc_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 32;
    localparam int CNT_W      = $clog2(DIVIDEND_W);
    localparam int PERIOD_W   = 27;
    localparam int PROD_W     = 32 + PERIOD_W;

    localparam logic [PERIOD_W-1:0] MS_PER_SECOND = PERIOD_W'(1000);
    localparam int unsigned         PERIOD_MIN    = 250;

    // Wrap window for sub-second periods: 2^32 / ceil(1000 / period)
    localparam logic [32:0]  CLOCK_SPAN = 33'h1_0000_0000;
    localparam int unsigned  WRAP_DIV   = (1000 + PERIOD_MIN - 1) / PERIOD_MIN;
    localparam logic [31:0]  WIN        = 32'(CLOCK_SPAN / WRAP_DIV);
    localparam int           WIN_SH     = $clog2(WIN);
    localparam logic [31:0]  WIN_Q      = WIN >> 2;
    localparam logic [31:0]  WIN_H      = WIN >> 1;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET      = 2'd1,
        CMD_TO_CODE  = 2'd2,
        CMD_TO_CLOCK = 2'd3
    } wcc_cmd_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_WAIT   = 5'b01000,
        S_FINISH = 5'b10000
    } wcc_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } wcc_div_req_t;

    function automatic logic [PERIOD_W-1:0] period_ms(input logic [2:0] sel);
        logic [PERIOD_W-1:0] p;
        case (sel)
            3'd0:    p = PERIOD_W'(250);
            3'd1:    p = PERIOD_W'(1000);
            3'd2:    p = PERIOD_W'(15000);
            3'd3:    p = PERIOD_W'(60000);
            3'd4:    p = PERIOD_W'(600000);
            3'd5:    p = PERIOD_W'(1800000);
            3'd6:    p = PERIOD_W'(3600000);
            default: p = PERIOD_W'(86400000);
        endcase
        return p;
    endfunction

    // Recover the wrapped high part of a sub-second code against a reference clock.
    function automatic logic [31:0] wrap_fix(input logic [31:0] clk_q,
                                             input logic [31:0] ref_in);
        logic [2:0]  n;
        logic [31:0] r;
        logic        edge_hit;
        n        = 3'd0;
        r        = ref_in;
        edge_hit = 1'b0;
        if (ref_in > WIN)
        begin
            n = 3'((ref_in - 32'd1) >> WIN_SH);
            r = ref_in - (32'(n) << WIN_SH);
        end
        if (r < WIN_Q)
        begin
            if (n != 3'd0)
            begin
                edge_hit = 1'b1;
                n        = n - 3'd1;
            end
        end
        else if (r > WIN_Q + WIN_H)
        begin
            edge_hit = 1'b1;
        end
        if (edge_hit && (clk_q < WIN_H))
        begin
            n = n + 3'd1;
        end
        return clk_q + (32'(n) << WIN_SH);
    endfunction

endpackage

/* design/wall_clock_time_code_converter.sv */
// Sequence: tick and set go from acceptance through launch and the 64-step serial divider
// to finish; conversions take a multiply step first; a conversion with an invalid scale
// goes straight to finish. A new command is accepted only when idle (busy low).
// done pulses for one cycle with the result; the receiver cannot stall it.
// rst_n is asynchronous, active low: timebase, anchors and clock reset to zero, block idle.
module wall_clock_time_code_converter #(
    parameter int unsigned TICKS_PER_SECOND = 1000000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [63:0] time_us,
    input  logic [31:0] clock_value,
    input  logic [3:0]  scale,
    input  logic [31:0] time_code,
    input  logic [31:0] reference_clock,
    output logic        done,
    output logic [31:0] answer,
    output logic [63:0] now_us,
    output logic [63:0] since_last_tick,
    output logic [31:0] clock_now,
    output logic        never_set,
    output logic        scale_error
);
    import wcc_pkg::*;

    // Architecture: a small sequencer drives one shared multiplier step and one
    // serial divider. The wall clock is cached in clock_reg and recomputed
    // after every tick or set, so conversions never need a second division.

    // sequencer and timekeeping state
    wcc_state_t           state_reg, state_next;
    logic [63:0]          cur_reg, cur_next;
    logic [63:0]          prev_reg, prev_next;
    logic [63:0]          anc_time_reg, anc_time_next;
    logic [31:0]          anc_clk_reg, anc_clk_next;
    logic [31:0]          clock_reg, clock_next;

    // per-beat working registers
    wcc_cmd_t             cmd_reg, cmd_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic                 wrap_en_reg, wrap_en_next;
    logic [31:0]          opa_reg, opa_next;
    logic [31:0]          ref_reg, ref_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [31:0]          answer_reg, answer_next;
    logic                 err_reg, err_next;

    wcc_cmd_t             cmd_in;
    logic                 accept;
    logic                 clk_op;
    logic [PERIOD_W-1:0]  mul_b;
    logic [PERIOD_W-1:0]  sel_period;
    wcc_div_req_t         div_req;
    logic                 div_done;
    logic [31:0]          div_q;

    assign cmd_in     = wcc_cmd_t'(command);
    assign accept     = start && (state_reg == S_IDLE);
    assign clk_op     = (cmd_reg == CMD_TICK) || (cmd_reg == CMD_SET);
    assign sel_period = period_ms(scale[2:0]);

    // clock->code multiplies the clock by 1000; code->clock multiplies by the period
    assign mul_b = (cmd_reg == CMD_TO_CODE) ? MS_PER_SECOND : period_reg;

    // divider operand selection
    always_comb
    begin
        div_req.start = (state_reg == S_LAUNCH);
        if (clk_op)
        begin
            div_req.dividend = cur_reg - anc_time_reg;
            div_req.divisor  = DIVISOR_W'(TICKS_PER_SECOND);
        end
        else
        begin
            div_req.dividend = {{(DIVIDEND_W-PROD_W){1'b0}}, prod_reg};
            div_req.divisor  = (cmd_reg == CMD_TO_CODE)
                             ? {{(DIVISOR_W-PERIOD_W){1'b0}}, period_reg}
                             : {{(DIVISOR_W-PERIOD_W){1'b0}}, MS_PER_SECOND};
        end
    end

    wcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        anc_time_next = anc_time_reg;
        anc_clk_next  = anc_clk_reg;
        clock_next    = clock_reg;
        cmd_next      = cmd_reg;
        period_next   = period_reg;
        wrap_en_next  = wrap_en_reg;
        opa_next      = opa_reg;
        ref_next      = ref_reg;
        prod_next     = prod_reg;
        answer_next   = answer_reg;
        err_next      = err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd_in;
                    answer_next = '0;
                    err_next    = 1'b0;
                    case (cmd_in)
                        CMD_TICK:
                        begin
                            prev_next  = cur_reg;
                            cur_next   = time_us;
                            state_next = S_LAUNCH;
                        end
                        CMD_SET:
                        begin
                            anc_clk_next  = clock_value;
                            anc_time_next = cur_reg;
                            state_next    = S_LAUNCH;
                        end
                        default:
                        begin
                            if (scale[3])
                            begin
                                // invalid scale: flag and skip all arithmetic
                                err_next   = 1'b1;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                period_next  = sel_period;
                                wrap_en_next = (cmd_in == CMD_TO_CLOCK) &&
                                               (sel_period < MS_PER_SECOND);
                                if (cmd_in == CMD_TO_CODE)
                                begin
                                    opa_next = (clock_value == '0) ? clock_reg : clock_value;
                                end
                                else
                                begin
                                    opa_next = time_code;
                                end
                                ref_next   = (reference_clock == '0) ? clock_reg
                                                                     : reference_clock;
                                state_next = S_MUL;
                            end
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(opa_reg * mul_b);
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (clk_op)
                    begin
                        clock_next = div_q + anc_clk_reg;
                    end
                    else if (wrap_en_reg)
                    begin
                        answer_next = wrap_fix(div_q, ref_reg);
                    end
                    else
                    begin
                        answer_next = div_q;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_reg      <= '0;
            prev_reg     <= '0;
            anc_time_reg <= '0;
            anc_clk_reg  <= '0;
            clock_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            prev_reg     <= prev_next;
            anc_time_reg <= anc_time_next;
            anc_clk_reg  <= anc_clk_next;
            clock_reg    <= clock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        period_reg  <= period_next;
        wrap_en_reg <= wrap_en_next;
        opa_reg     <= opa_next;
        ref_reg     <= ref_next;
        prod_reg    <= prod_next;
        answer_reg  <= answer_next;
        err_reg     <= err_next;
    end

    // result beat
    assign busy            = (state_reg != S_IDLE);
    assign done            = (state_reg == S_FINISH);
    assign answer          = answer_reg;
    assign now_us          = cur_reg;
    assign since_last_tick = cur_reg - prev_reg;
    assign clock_now       = clock_reg;
    assign never_set       = (anc_time_reg == '0) && (anc_clk_reg == '0);
    assign scale_error     = err_reg;

`include "wall_clock_time_code_converter_macros.svh"

    `WCC_ASSERT_NEXT(a_done_single, done, !done)
    `WCC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `WCC_ASSERT_NOW(a_div_done_wait, div_done, state_reg == S_WAIT)
    `WCC_ASSERT_NOW(a_err_zero, done && scale_error, answer == '0)
    `WCC_ASSERT_NOW(a_err_conv, done && scale_error,
        (cmd_reg == CMD_TO_CODE) || (cmd_reg == CMD_TO_CLOCK))

endmodule

/* design/wcc_div.sv */
module wcc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  wcc_pkg::wcc_div_req_t req,
    output logic                done,
    output logic [31:0]         quotient
);
    import wcc_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // restoring step: one quotient bit per cycle, MSB first
    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]} - {1'b0, dsr_reg};
    assign fits  = ~trial[DIVISOR_W];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = '1;
            rem_next   = '0;
            dvd_next   = req.dividend;
            dsr_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? trial[DIVISOR_W-1:0]
                              : {rem_reg[DIVISOR_W-2:0], dvd_reg[DIVIDEND_W-1]};
            dvd_next   = {dvd_reg[DIVIDEND_W-2:0], fits};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[31:0];

endmodule
